// File: rtl/core/rkpc_pkg.sv
// Shared constants and controller/datapath interface types for the keypad push cost block.
package rkpc_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int LETTER_W          = 5;
  localparam int KEY_W             = 5;
  localparam int TOTAL_W           = 21;

  localparam logic [KEY_W-1:0]   KEY_COUNT_RESET = KEY_W'(8);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic count;       // add the accepted letter to the histogram
    logic begin_rank;  // last letter accepted: clear the total and element index
    logic load;        // capture the head entry as the current element
    logic cmp;         // compare head against current element, rotate
    logic mul;         // form count times weight
    logic add;         // accumulate product, advance element
    logic clear_hist;  // drop all counts after the word
  } cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic cmp_last;    // final comparison of this element
    logic elem_last;   // final element of the ranking pass
  } status_t;

endpackage

// File: rtl/core/rkpc_ctrl.sv
// Sequencer for the histogram count and ranking passes.
module rkpc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            last,
  input  rkpc_pkg::status_t status,
  output rkpc_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import rkpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_MUL,
    ST_ADD
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    case (state)
      ST_IDLE: begin
        cmd.count      = start;
        cmd.begin_rank = start && last;
        if (start && last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (status.cmp_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add        = 1'b1;
        cmd.clear_hist = status.elem_last;
        state_next     = status.elem_last ? ST_IDLE : ST_LOAD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_ADD) && status.elem_last;
    end
  end

endmodule

// File: rtl/core/rkpc_dp.sv
// Histogram, rotating rank search, weight tracking and saturating total.
module rkpc_dp #(
  parameter int ALPHABET_SIZE = rkpc_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_WIDTH   = rkpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rkpc_pkg::cmd_t                cmd,
  input  logic [rkpc_pkg::LETTER_W-1:0] letter,
  input  logic                          key_count_we,
  input  logic [rkpc_pkg::KEY_W-1:0]    key_count,
  output rkpc_pkg::status_t             status,
  output logic [rkpc_pkg::TOTAL_W-1:0]  total_pushes
);
  import rkpc_pkg::*;

  localparam int IW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int WW = $clog2(ALPHABET_SIZE + 1);
  localparam int PW = COUNT_WIDTH + WW;
  localparam int SW = ((PW > TOTAL_W) ? PW : TOTAL_W) + 1;
  localparam int LW = (IW > LETTER_W) ? IW + 1 : LETTER_W + 1;

  logic [COUNT_WIDTH-1:0] hist [ALPHABET_SIZE];
  logic [COUNT_WIDTH-1:0] cur;
  logic [KEY_W-1:0]       keys_reg;
  logic [KEY_W-1:0]       keys_eff;
  logic [KEY_W-1:0]       rem;
  logic [WW-1:0]          weight;
  logic [IW-1:0]          k;
  logic [IW-1:0]          elem;
  logic [PW-1:0]          prod;
  logic [SW-1:0]          sum;
  logic                   rotate;
  logic                   tie_before;
  logic                   outranks;

  assign rotate   = cmd.load || cmd.cmp || cmd.mul;
  assign keys_eff = (keys_reg == '0) ? KEY_W'(1) : keys_reg;

  // Head holds element (elem + k) mod N; it precedes elem once that wraps.
  assign tie_before = ((IW+1)'(k) + (IW+1)'(elem)) >= (IW+1)'(ALPHABET_SIZE);
  assign outranks   = (hist[0] > cur) || ((hist[0] == cur) && tie_before);

  assign status.cmp_last  = (k == IW'(ALPHABET_SIZE - 1));
  assign status.elem_last = (elem == IW'(ALPHABET_SIZE - 1));

  assign sum = SW'(total_pushes) + SW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_reg <= KEY_COUNT_RESET;
    end else if (key_count_we) begin
      keys_reg <= key_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_hist) begin
      for (int e = 0; e < ALPHABET_SIZE; e++) begin
        hist[e] <= '0;
      end
    end else if (rotate) begin
      for (int e = 0; e < ALPHABET_SIZE - 1; e++) begin
        hist[e] <= hist[e+1];
      end
      hist[ALPHABET_SIZE-1] <= hist[0];
    end else if (cmd.count) begin
      for (int e = 0; e < ALPHABET_SIZE; e++) begin
        if ((LW'(letter) == LW'(e)) && (hist[e] != {COUNT_WIDTH{1'b1}})) begin
          hist[e] <= hist[e] + COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_rank) begin
      elem         <= '0;
      total_pushes <= '0;
    end else if (cmd.add) begin
      elem         <= elem + IW'(1);
      total_pushes <= (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
    if (cmd.load) begin
      cur    <= hist[0];
      k      <= IW'(1);
      rem    <= '0;
      weight <= WW'(1);
    end else if (cmd.cmp) begin
      k <= k + IW'(1);
      if (outranks) begin
        if (rem == keys_eff - KEY_W'(1)) begin
          rem    <= '0;
          weight <= weight + WW'(1);
        end else begin
          rem <= rem + KEY_W'(1);
        end
      end
    end
    if (cmd.mul) begin
      prod <= PW'(cur) * PW'(weight);
    end
  end

endmodule

// File: rtl/core/ranked_keypad_push_cost_top.sv
// Top level of the ranked keypad push cost block.
// A letter without last is counted while busy stays low.
// A last letter is counted and starts the ranking pass: load, compare, multiply and add
// for each element; done pulses the cycle after the final add, with total_pushes valid.
// Throughput: one letter per cycle while busy is low; no letter is taken during a ranking pass.
// Reset (rst, synchronous): clears counts and sequencer, key_count returns to 8.
// The receiver cannot stall: done is a one-cycle strobe.
module ranked_keypad_push_cost_top #(
  parameter int ALPHABET_SIZE = rkpc_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_WIDTH   = rkpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rkpc_pkg::LETTER_W-1:0] letter,
  input  logic                          last,
  output logic                          busy,
  input  logic                          key_count_we,
  input  logic [rkpc_pkg::KEY_W-1:0]    key_count,
  output logic                          done,
  output logic [rkpc_pkg::TOTAL_W-1:0]  total_pushes
);
  import rkpc_pkg::*;

  // The ranking pass avoids a sort: the histogram rotates past a fixed head
  // tap, and for each element the number of entries that outrank it (larger,
  // or equal and earlier) sets its weight. A remainder counter against
  // key_count advances the weight, so no divider is needed.
  cmd_t    cmd;
  status_t status;

  rkpc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rkpc_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .letter       (letter),
    .key_count_we (key_count_we),
    .key_count    (key_count),
    .status       (status),
    .total_pushes (total_pushes)
  );

  // A finished word is reported only once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // A word's result is a single strobe.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // Only an accepted last letter starts the ranking pass.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("last letter did not start ranking");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    (!busy && !(start && last)) |=> !busy)
    else $error("busy rose without a last letter");

endmodule
